@@ design/assert_macros.svh @@
// assertion helpers used by the checked module mi4_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MI4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define MI4_ASSERT_NEXT(label, cond, expct, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) else $error(msg);

`endif

@@ design/mi4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg
// shared constants, command types and index helpers for the 4x4 inverter
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ELEM_W      = 32;
  localparam int IDX_W       = 4;
  localparam int N_ELEM      = 16;
  localparam int COF_W       = 97;
  localparam int NUM_W       = 96 + 2 * FRAC_BITS;
  localparam int WIDE_W      = 160;
  localparam int LIMB_W      = 32;
  localparam int N_LIMBS     = WIDE_W / LIMB_W;
  localparam int LIMB_IDX_W  = $clog2(N_LIMBS);
  localparam int BIT_CNT_W   = $clog2(NUM_W);
  localparam int TERM_W      = 3;
  localparam int FACT_W      = 2;
  localparam int PP_W        = LIMB_W + ELEM_W + 1;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACC_CLR,
    OP_LOAD_ELEM,
    OP_LOAD_COF,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_ACC_ADD,
    OP_COF_STORE,
    OP_DET_SAVE,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_RES_SAVE,
    OP_RES_ZERO
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_COF_INIT,
    S_COF_LOAD,
    S_COF_MSTART,
    S_COF_MSTEP,
    S_COF_ACC,
    S_COF_STORE,
    S_DET_INIT,
    S_DET_LOAD,
    S_DET_MSTART,
    S_DET_MSTEP,
    S_DET_ACC,
    S_DET_SAVE,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_RES_SAVE,
    S_RES_ZERO,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic                  wr_en;
    logic [IDX_W-1:0]      elem_addr;
    logic [IDX_W-1:0]      cof_addr;
    logic [LIMB_IDX_W-1:0] limb;
    logic                  neg;
    logic [IDX_W-1:0]      res_index;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } status_t;

  // column of the 3x3 minor used by factor f of permutation term t
  function automatic logic [1:0] perm_col(input logic [TERM_W-1:0] t,
                                          input logic [FACT_W-1:0] f);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      3'd5:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    unique case (f)
      2'd0:    return p[1:0];
      2'd1:    return p[3:2];
      default: return p[5:4];
    endcase
  endfunction

  // flat matrix address of factor f of term t of the cofactor at index k
  function automatic logic [IDX_W-1:0] elem_addr(input logic [IDX_W-1:0] k,
                                                 input logic [TERM_W-1:0] t,
                                                 input logic [FACT_W-1:0] f);
    logic [1:0] r, c, p, rr, cc;
    r  = k[3:2];
    c  = k[1:0];
    p  = perm_col(t, f);
    rr = (f < r) ? f : 2'(f + 2'd1);
    cc = (p < c) ? p : 2'(p + 2'd1);
    return {rr, cc};
  endfunction

  // odd permutation xor checkerboard sign of the cofactor
  function automatic logic term_neg(input logic [IDX_W-1:0] k,
                                    input logic [TERM_W-1:0] t);
    return (t >= 3'd3) ^ k[2] ^ k[0];
  endfunction

endpackage

@@ design/matrix4_inverse_core.sv @@
`timescale 1ns / 1ps
// throughput: one load per cycle while idle; one inversion at a time
// the arithmetic uses a single 33x32 limb multiplier and a one-bit-per-cycle divider
// reset: synchronous active low, clears the matrix store and the sequencer
// ----------------------------------------------------------------------------
// matrix4_inverse_core
// 4x4 Q16.16 matrix inverse by cofactors with exact wide arithmetic
// ----------------------------------------------------------------------------
module matrix4_inverse_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mi4_pkg::IN_DATA_W-1:0]     in_tdata,   // element_index, element_value, pad
  input  logic                              in_tuser,   // go
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mi4_pkg::OUT_DATA_W-1:0]    out_tdata,  // result_index, result_value, pad
  output logic [1:0]                        out_tuser,  // clipped, singular
  output logic                              out_tlast   // last_result
);
  import mi4_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [IDX_W-1:0]  res_index;
  logic [ELEM_W-1:0] res_value;
  logic              res_clipped, res_singular;

  // sequencer: loads in idle, then walks cofactors, determinant and divides (zero results if singular)
  mi4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .go         (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  // arithmetic and stores; result register holds until the item is taken
  mi4_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .wr_index     (in_tdata[IDX_W-1:0]),
    .wr_value     (in_tdata[IDX_W +: ELEM_W]),
    .res_index    (res_index),
    .res_value    (res_value),
    .res_clipped  (res_clipped),
    .res_singular (res_singular),
    .res_last     (out_tlast)
  );

  // output packing: index low, value above, zero pad to bytes
  assign out_tdata = {{(OUT_DATA_W-IDX_W-ELEM_W){1'b0}}, res_value, res_index};
  assign out_tuser = {res_singular, res_clipped};

endmodule

@@ design/mi4_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_datapath
// matrix store, cofactor store, limb multiplier, accumulator and divider
// ----------------------------------------------------------------------------
module mi4_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mi4_pkg::cmd_t                 cmd,
  output mi4_pkg::status_t              status,
  input  logic [mi4_pkg::IDX_W-1:0]     wr_index,
  input  logic [mi4_pkg::ELEM_W-1:0]    wr_value,
  output logic [mi4_pkg::IDX_W-1:0]     res_index,
  output logic [mi4_pkg::ELEM_W-1:0]    res_value,
  output logic                          res_clipped,
  output logic                          res_singular,
  output logic                          res_last
);
  import mi4_pkg::*;

  logic [ELEM_W-1:0] matrix_r [N_ELEM];
  logic [COF_W-1:0]  cof_r [N_ELEM];
  logic [WIDE_W-1:0] src_r, prod_r, acc_r, dmag_r, rem_r;
  logic [NUM_W-1:0]  num_r;
  logic [ELEM_W-1:0] q_r;
  logic              ovf_r, dneg_r, qneg_r;

  logic [ELEM_W-1:0] elem;
  logic [COF_W-1:0]  cof_rd, cof_mag;
  logic [LIMB_W-1:0] src_limb;
  logic              limb_ext;
  logic signed [PP_W-1:0] pp;
  logic [WIDE_W-1:0] pp_w, prod_sum, rem2;
  logic              ge;
  logic [ELEM_W-1:0] limit, mag;
  logic              over;

  assign elem     = matrix_r[cmd.elem_addr];
  assign cof_rd   = cof_r[cmd.cof_addr];
  assign cof_mag  = cof_rd[COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;
  assign src_limb = src_r[LIMB_W*cmd.limb +: LIMB_W];
  assign limb_ext = (cmd.limb == LIMB_IDX_W'(N_LIMBS-1)) ? src_limb[LIMB_W-1] : 1'b0;
  assign pp       = $signed({limb_ext, src_limb}) * $signed(elem);
  assign pp_w     = {{(WIDE_W-PP_W){pp[PP_W-1]}}, pp};
  assign prod_sum = prod_r + (pp_w << (LIMB_W * cmd.limb));
  assign rem2     = {rem_r[WIDE_W-2:0], num_r[NUM_W-1]};
  assign ge       = (rem2 >= dmag_r);
  assign limit    = qneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign over     = ovf_r || (q_r > limit);
  assign mag      = over ? limit : q_r;

  assign status.det_zero = (acc_r == '0);

  // matrix store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_ELEM; i++) matrix_r[i] <= '0;
    end else if (cmd.wr_en) begin
      matrix_r[wr_index] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COF_STORE) cof_r[cmd.cof_addr] <= acc_r[COF_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_ACC_CLR:   acc_r <= '0;
      OP_LOAD_ELEM: prod_r <= {{(WIDE_W-ELEM_W){elem[ELEM_W-1]}}, elem};
      OP_LOAD_COF:  prod_r <= {{(WIDE_W-COF_W){cof_rd[COF_W-1]}}, cof_rd};
      OP_MUL_START: begin
        src_r  <= prod_r;
        prod_r <= '0;
      end
      OP_MUL_STEP:  prod_r <= prod_sum;
      OP_ACC_ADD:   acc_r <= cmd.neg ? (acc_r - prod_r) : (acc_r + prod_r);
      OP_COF_STORE: begin
      end
      OP_DET_SAVE: begin
        dneg_r <= acc_r[WIDE_W-1];
        dmag_r <= acc_r[WIDE_W-1] ? (~acc_r + 1'b1) : acc_r;
      end
      OP_DIV_LOAD: begin
        num_r  <= NUM_W'(cof_mag) << (2 * FRAC_BITS);
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        qneg_r <= cof_rd[COF_W-1] ^ dneg_r;
      end
      OP_DIV_STEP: begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        rem_r <= ge ? (rem2 - dmag_r) : rem2;
        q_r   <= {q_r[ELEM_W-2:0], ge};
        ovf_r <= ovf_r | q_r[ELEM_W-1];
      end
      OP_RES_SAVE: begin
        res_index    <= cmd.res_index;
        res_value    <= qneg_r ? (~mag + 1'b1) : mag;
        res_clipped  <= over;
        res_singular <= 1'b0;
        res_last     <= (cmd.res_index == IDX_W'(N_ELEM-1));
      end
      OP_RES_ZERO: begin
        res_index    <= cmd.res_index;
        res_value    <= '0;
        res_clipped  <= 1'b0;
        res_singular <= 1'b1;
        res_last     <= (cmd.res_index == IDX_W'(N_ELEM-1));
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/mi4_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ctrl
// sequencer for cofactors, determinant, division and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mi4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              go,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mi4_pkg::cmd_t     cmd,
  input  mi4_pkg::status_t  status
);
  import mi4_pkg::*;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  logic [TERM_W-1:0]     t_r, t_nxt;
  logic [FACT_W-1:0]     f_r, f_nxt;
  logic [LIMB_IDX_W-1:0] limb_r, limb_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic                  sing_r, sing_nxt;
  logic                  last_limb;

  assign last_limb = (limb_r == LIMB_IDX_W'(N_LIMBS-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      t_r     <= '0;
      f_r     <= '0;
      limb_r  <= '0;
      bit_r   <= '0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      f_r     <= f_nxt;
      limb_r  <= limb_nxt;
      bit_r   <= bit_nxt;
      sing_r  <= sing_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    f_nxt     = f_r;
    limb_nxt  = limb_r;
    bit_nxt   = bit_r;
    sing_nxt  = sing_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && go) begin
          state_nxt = S_COF_INIT;
          k_nxt     = '0;
        end
      end
      S_COF_INIT: begin
        t_nxt     = '0;
        state_nxt = S_COF_LOAD;
      end
      S_COF_LOAD: begin
        f_nxt     = 2'd1;
        state_nxt = S_COF_MSTART;
      end
      S_COF_MSTART: begin
        limb_nxt  = '0;
        state_nxt = S_COF_MSTEP;
      end
      S_COF_MSTEP: begin
        limb_nxt = LIMB_IDX_W'(limb_r + 1'b1);
        if (last_limb) begin
          if (f_r == 2'd2) begin
            state_nxt = S_COF_ACC;
          end else begin
            f_nxt     = 2'(f_r + 2'd1);
            state_nxt = S_COF_MSTART;
          end
        end
      end
      S_COF_ACC: begin
        if (t_r == 3'd5) begin
          state_nxt = S_COF_STORE;
        end else begin
          t_nxt     = 3'(t_r + 3'd1);
          state_nxt = S_COF_LOAD;
        end
      end
      S_COF_STORE: begin
        k_nxt = 4'(k_r + 4'd1);
        if (k_r == IDX_W'(N_ELEM-1)) state_nxt = S_DET_INIT;
        else                         state_nxt = S_COF_INIT;
      end
      S_DET_INIT: begin
        k_nxt     = '0;
        state_nxt = S_DET_LOAD;
      end
      S_DET_LOAD:   state_nxt = S_DET_MSTART;
      S_DET_MSTART: begin
        limb_nxt  = '0;
        state_nxt = S_DET_MSTEP;
      end
      S_DET_MSTEP: begin
        limb_nxt = LIMB_IDX_W'(limb_r + 1'b1);
        if (last_limb) state_nxt = S_DET_ACC;
      end
      S_DET_ACC: begin
        if (k_r == 4'd3) begin
          state_nxt = S_DET_SAVE;
        end else begin
          k_nxt     = 4'(k_r + 4'd1);
          state_nxt = S_DET_LOAD;
        end
      end
      S_DET_SAVE: begin
        k_nxt     = '0;
        sing_nxt  = status.det_zero;
        state_nxt = status.det_zero ? S_RES_ZERO : S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        bit_nxt   = '0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        bit_nxt = BIT_CNT_W'(bit_r + 1'b1);
        if (bit_r == BIT_CNT_W'(NUM_W-1)) state_nxt = S_RES_SAVE;
      end
      S_RES_SAVE: state_nxt = S_OUT;
      S_RES_ZERO: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          k_nxt = 4'(k_r + 4'd1);
          if (k_r == IDX_W'(N_ELEM-1)) state_nxt = S_IDLE;
          else if (sing_r)             state_nxt = S_RES_ZERO;
          else                         state_nxt = S_DIV_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands and handshakes
  always_comb begin
    cmd           = '0;
    cmd.op        = OP_IDLE;
    cmd.limb      = limb_r;
    cmd.res_index = k_r;
    in_tready     = (state_r == S_IDLE);
    out_tvalid    = (state_r == S_OUT);
    cmd.wr_en     = in_tvalid && (state_r == S_IDLE);
    unique case (state_r)
      S_COF_INIT, S_DET_INIT: cmd.op = OP_ACC_CLR;
      S_COF_LOAD: begin
        cmd.op        = OP_LOAD_ELEM;
        cmd.elem_addr = elem_addr(k_r, t_r, 2'd0);
      end
      S_COF_MSTART, S_DET_MSTART: cmd.op = OP_MUL_START;
      S_COF_MSTEP: begin
        cmd.op        = OP_MUL_STEP;
        cmd.elem_addr = elem_addr(k_r, t_r, f_r);
      end
      S_COF_ACC: begin
        cmd.op  = OP_ACC_ADD;
        cmd.neg = term_neg(k_r, t_r);
      end
      S_COF_STORE: begin
        cmd.op       = OP_COF_STORE;
        cmd.cof_addr = k_r;
      end
      S_DET_LOAD: begin
        cmd.op       = OP_LOAD_COF;
        cmd.cof_addr = k_r;
      end
      S_DET_MSTEP: begin
        cmd.op        = OP_MUL_STEP;
        cmd.elem_addr = k_r;
      end
      S_DET_ACC:  cmd.op = OP_ACC_ADD;
      S_DET_SAVE: cmd.op = OP_DET_SAVE;
      S_DIV_LOAD: begin
        cmd.op       = OP_DIV_LOAD;
        cmd.cof_addr = {k_r[1:0], k_r[3:2]};
      end
      S_DIV_STEP: cmd.op = OP_DIV_STEP;
      S_RES_SAVE: cmd.op = OP_RES_SAVE;
      S_RES_ZERO: cmd.op = OP_RES_ZERO;
      default:    cmd.op = OP_IDLE;
    endcase
  end

  `MI4_ASSERT(a_no_load_while_busy, !(in_tready && out_tvalid), "input open during output")
  `MI4_ASSERT_NEXT(a_out_hold, (state_r == S_OUT) && !out_tready, state_r == S_OUT, "result dropped")
  `MI4_ASSERT_NEXT(a_cof_to_det, (state_r == S_COF_STORE) && (k_r == 4'd15), state_r == S_DET_INIT, "determinant phase skipped")
  `MI4_ASSERT_NEXT(a_go_starts, in_tvalid && in_tready && go, state_r == S_COF_INIT, "go not taken")

endmodule
